// File: rtl/bmf_pkg.sv
// Shared constants, item types and the window evaluation function of the morphology filter.
package bmf_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int MAX_ELEMENT = 5;
    localparam int HALF        = MAX_ELEMENT / 2;
    localparam int MASK_BITS   = MAX_ELEMENT * MAX_ELEMENT;
    localparam int LINES       = MAX_ELEMENT - 1;

    localparam int SIZE_W     = 11;
    localparam int ESZ_W      = 3;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int POS_W      = $clog2(MAX_HEIGHT) + 2;
    localparam int CNT_W      = 21;
    localparam int DLY_W      = SIZE_W + 1;
    localparam int LAT_W      = SIZE_W + 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    // item commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // filter modes
    localparam logic [1:0] MODE_ERODE  = 2'd0;
    localparam logic [1:0] MODE_DILATE = 2'd1;
    localparam logic [1:0] MODE_OPEN   = 2'd2;
    localparam logic [1:0] MODE_CLOSE  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd5;

    typedef struct packed {
        logic       cmd;
        logic [7:0] pixel;
    } t_in_item;

    typedef struct packed {
        logic foreground;
        logic end_of_frame;
    } t_out_item;

    // window indexed [row tap][column tap], tap 0 newest
    typedef logic [MAX_ELEMENT-1:0][MAX_ELEMENT-1:0] t_window;

    // One erosion or dilation pass over a window; rv/cv flag taps inside the image.
    function automatic logic pass_eval(
        input t_window                win,
        input logic [MAX_ELEMENT-1:0] rv,
        input logic [MAX_ELEMENT-1:0] cv,
        input logic [MASK_BITS-1:0]   mask,
        input logic [ESZ_W-1:0]       rows,
        input logic [ESZ_W-1:0]       cols,
        input logic                   dil
    );
        logic [ESZ_W-1:0] ar;
        logic [ESZ_W-1:0] ac;
        logic [ESZ_W:0]   ri;
        logic [ESZ_W:0]   ki;
        logic             en;
        logic             val;
        logic             any_hit;
        logic             all_ok;
        ar      = rows >> 1;
        ac      = cols >> 1;
        any_hit = 1'b0;
        all_ok  = 1'b1;
        for (int u = 0; u < MAX_ELEMENT; u++) begin
            for (int v = 0; v < MAX_ELEMENT; v++) begin
                en = mask[u*MAX_ELEMENT+v] && (ESZ_W'(u) < rows) && (ESZ_W'(v) < cols);
                if (dil) begin
                    ri = (ESZ_W+1)'(HALF + u) - {1'b0, ar};
                    ki = (ESZ_W+1)'(HALF + v) - {1'b0, ac};
                end else begin
                    ri = (ESZ_W+1)'(HALF) + {1'b0, ar} - (ESZ_W+1)'(u);
                    ki = (ESZ_W+1)'(HALF) + {1'b0, ac} - (ESZ_W+1)'(v);
                end
                val = 1'b0;
                if (ri < (ESZ_W+1)'(MAX_ELEMENT) && ki < (ESZ_W+1)'(MAX_ELEMENT)) begin
                    val = rv[ri[ESZ_W-1:0]] & cv[ki[ESZ_W-1:0]]
                        & win[ri[ESZ_W-1:0]][ki[ESZ_W-1:0]];
                end
                any_hit = any_hit | (en & val);
                all_ok  = all_ok & (~en | val);
            end
        end
        return dil ? any_hit : all_ok;
    endfunction

endpackage

// File: rtl/binary_morphology_filter.sv
// Top level: streaming binary erosion, dilation, opening and closing over a raster frame.
//
// Items arrive on the input channel (valid/ready) in raster order: a pixel item carries one
// grayscale pixel, nonzero meaning foreground; a drain item releases a pending result once a
// frame's pixels are all in. Results leave on the output channel (valid/ready), one bit each,
// the last of a frame flagged with end_of_frame.
// Each pass runs a 5x5 window fed by a 4-line store (one RAM, one write and one read a cycle while stepping);
// a second window and line store form the cascade for opening and closing. With W the frame
// width, one pass lags the input by 2*W+2 items and the cascade by twice that, so the first
// result comes with that many items in hand; each later pixel or drain item brings one more.
// Throughput is one item a cycle while the receiver keeps up; the result is registered and
// valid in the cycle after acceptance. Where the frame is shorter than the lag, the block
// steps its windows alone after the last pixel (ready low) until its steps reach the lag.
// Configuration is sampled at the first pixel of a frame. A pixel after a frame's last pixel
// starts a new frame and drops whatever of the old one is still pending.
// Reset puts the registers at their defaults and the block idle; line stores are not cleared.
// A stalled receiver holds the result register; a new item is taken only when that register
// is free or being emptied in the same cycle.
module binary_morphology_filter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  bmf_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output bmf_pkg::t_out_item                o_out_data,
    input  logic                              i_cfg_we,
    input  logic [bmf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bmf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import bmf_pkg::*;

    // configuration registers
    logic [1:0]           r_cfg_mode;
    logic [MASK_BITS-1:0] r_cfg_mask;
    logic [ESZ_W-1:0]     r_cfg_rows;
    logic [ESZ_W-1:0]     r_cfg_cols;
    logic [SIZE_W-1:0]    r_cfg_w;
    logic [SIZE_W-1:0]    r_cfg_h;

    // frame settings latched at frame start
    logic [1:0]           r_cur_mode;
    logic [MASK_BITS-1:0] r_cur_mask;
    logic [ESZ_W-1:0]     r_cur_rows;
    logic [ESZ_W-1:0]     r_cur_cols;
    logic [SIZE_W-1:0]    r_cur_w;
    logic [SIZE_W-1:0]    r_cur_h;
    logic [CNT_W-1:0]     r_n;
    logic [DLY_W-1:0]     r_d;
    logic [LAT_W-1:0]     r_l;

    // frame control
    logic                 r_active;
    logic [CNT_W-1:0]     r_s;
    logic [CNT_W-1:0]     r_out_cnt;
    logic [ADDR_W-1:0]    r_addr;
    logic [POS_W-1:0]     r_r1, r_r2;
    logic [ADDR_W-1:0]    r_c1, r_c2;

    // window datapath
    logic [LINES-1:0]     mem1 [MAX_WIDTH];
    logic [LINES-1:0]     mem2 [MAX_WIDTH];
    logic [LINES-1:0]     r_rd1, r_rd2, r_last1, r_last2;
    logic                 r_byp;
    logic [MAX_ELEMENT-1:0][MAX_ELEMENT-2:0] r_h1, r_h2;

    logic                 r_out_valid;
    t_out_item            r_out_data;

    // combinational
    logic                 pix, input_done, auto_step, out_free, acc, start;
    logic                 drain_step, step, produce, adv1, adv2;
    logic [SIZE_W-1:0]    clamp_w, clamp_h, w_eff;
    logic [ESZ_W-1:0]     clamp_rows, clamp_cols;
    logic [CNT_W-1:0]     n_n;
    logic [DLY_W-1:0]     n_d;
    logic [LAT_W-1:0]     n_l;
    logic [ADDR_W-1:0]    a_eff, a_next;
    logic [LINES-1:0]     ln1, ln2, wv1, wv2;
    t_window              nw1, nw2;
    logic [MAX_ELEMENT-1:0] rv1, cv1, rv2, cv2;
    logic                 dil1, dil2, res1, res2;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] hi);
        if (v == '0) return SIZE_W'(1);
        return (v > hi) ? hi : v;
    endfunction

    function automatic logic [ESZ_W-1:0] clamp_elem(input logic [ESZ_W-1:0] v);
        if (v == '0) return ESZ_W'(1);
        return (v > ESZ_W'(MAX_ELEMENT)) ? ESZ_W'(MAX_ELEMENT) : v;
    endfunction

    // row taps inside the image around a centre row
    function automatic logic [MAX_ELEMENT-1:0] row_ok(input logic [POS_W-1:0] row,
                                                      input logic [SIZE_W-1:0] h);
        logic signed [POS_W+1:0] t;
        logic [MAX_ELEMENT-1:0]  res;
        for (int r = 0; r < MAX_ELEMENT; r++) begin
            t = $signed({2'b00, row}) + (POS_W+2)'(HALF - r);
            res[r] = !t[POS_W+1] && (t < $signed({3'b000, h}));
        end
        return res;
    endfunction

    // column taps inside the image around a centre column
    function automatic logic [MAX_ELEMENT-1:0] col_ok(input logic [ADDR_W-1:0] col,
                                                      input logic [SIZE_W-1:0] w);
        logic signed [ADDR_W+1:0] t;
        logic [MAX_ELEMENT-1:0]   res;
        for (int k = 0; k < MAX_ELEMENT; k++) begin
            t = $signed({2'b00, col}) + (ADDR_W+2)'(HALF - k);
            res[k] = !t[ADDR_W+1] && (t < $signed({1'b0, w}));
        end
        return res;
    endfunction

    // handshake and step control
    always_comb begin
        pix        = (i_in_data.cmd == CMD_PIXEL);
        input_done = r_active && (r_s >= r_n);
        auto_step  = input_done && (r_s < CNT_W'(r_l));
        out_free   = !r_out_valid || i_out_ready;
        o_in_ready = out_free && !auto_step;
        acc        = i_in_valid && o_in_ready;
        start      = acc && pix && (!r_active || input_done);
        drain_step = acc && !pix && input_done && (r_out_cnt < r_n);
        step       = (acc && pix) || auto_step || drain_step;
        produce    = step && !start && (r_s >= CNT_W'(r_l)) && (r_out_cnt < r_n);
        adv1       = step && !start && (r_s >= CNT_W'(r_d));
        adv2       = step && !start && (r_s >= CNT_W'({r_d, 1'b0}));
    end

    // frame settings for a frame that starts now
    always_comb begin
        logic [2*SIZE_W-1:0] prod;
        clamp_w    = clamp_size(r_cfg_w, SIZE_W'(MAX_WIDTH));
        clamp_h    = clamp_size(r_cfg_h, SIZE_W'(MAX_HEIGHT));
        clamp_rows = clamp_elem(r_cfg_rows);
        clamp_cols = clamp_elem(r_cfg_cols);
        prod       = clamp_w * clamp_h;
        n_n        = prod[CNT_W-1:0];
        n_d        = DLY_W'(HALF) * DLY_W'(clamp_w) + DLY_W'(HALF);
        n_l        = (r_cfg_mode == MODE_OPEN || r_cfg_mode == MODE_CLOSE)
                     ? {n_d, 1'b0} : {1'b0, n_d};
    end

    // line store addressing, shared by both passes
    always_comb begin
        w_eff  = start ? clamp_w : r_cur_w;
        a_eff  = start ? '0 : r_addr;
        a_next = (({1'b0, a_eff} + SIZE_W'(1)) == w_eff) ? '0 : a_eff + ADDR_W'(1);
    end

    // first pass window and result
    always_comb begin
        ln1 = r_byp ? r_last1 : r_rd1;
        for (int r = 0; r < MAX_ELEMENT; r++) begin
            for (int k = 1; k < MAX_ELEMENT; k++) begin
                nw1[r][k] = r_h1[r][k-1];
            end
        end
        nw1[0][0] = acc && pix && (i_in_data.pixel != 8'd0);
        for (int r = 1; r < MAX_ELEMENT; r++) begin
            nw1[r][0] = ln1[r-1];
        end
        for (int r = 0; r < LINES; r++) begin
            wv1[r] = nw1[r][0];
        end
        dil1 = (r_cur_mode == MODE_DILATE) || (r_cur_mode == MODE_CLOSE);
        rv1  = row_ok(r_r1, r_cur_h);
        cv1  = col_ok(r_c1, r_cur_w);
        res1 = pass_eval(nw1, rv1, cv1, r_cur_mask, r_cur_rows, r_cur_cols, dil1);
    end

    // second pass window, fed by the first pass result
    always_comb begin
        ln2 = r_byp ? r_last2 : r_rd2;
        for (int r = 0; r < MAX_ELEMENT; r++) begin
            for (int k = 1; k < MAX_ELEMENT; k++) begin
                nw2[r][k] = r_h2[r][k-1];
            end
        end
        nw2[0][0] = res1;
        for (int r = 1; r < MAX_ELEMENT; r++) begin
            nw2[r][0] = ln2[r-1];
        end
        for (int r = 0; r < LINES; r++) begin
            wv2[r] = nw2[r][0];
        end
        dil2 = (r_cur_mode == MODE_OPEN);
        rv2  = row_ok(r_r2, r_cur_h);
        cv2  = col_ok(r_c2, r_cur_w);
        res2 = pass_eval(nw2, rv2, cv2, r_cur_mask, r_cur_rows, r_cur_cols, dil2);
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mode <= MODE_ERODE;
            r_cfg_mask <= MASK_BITS'(2274);
            r_cfg_rows <= ESZ_W'(3);
            r_cfg_cols <= ESZ_W'(3);
            r_cfg_w    <= SIZE_W'(MAX_WIDTH);
            r_cfg_h    <= SIZE_W'(MAX_HEIGHT);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MODE:   r_cfg_mode <= i_cfg_data[1:0];
                REG_MASK:   r_cfg_mask <= i_cfg_data[MASK_BITS-1:0];
                REG_ROWS:   r_cfg_rows <= i_cfg_data[ESZ_W-1:0];
                REG_COLS:   r_cfg_cols <= i_cfg_data[ESZ_W-1:0];
                REG_WIDTH:  r_cfg_w    <= i_cfg_data[SIZE_W-1:0];
                REG_HEIGHT: r_cfg_h    <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // frame settings latch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_mode <= MODE_ERODE;
            r_cur_mask <= '0;
            r_cur_rows <= ESZ_W'(1);
            r_cur_cols <= ESZ_W'(1);
            r_cur_w    <= SIZE_W'(1);
            r_cur_h    <= SIZE_W'(1);
            r_n        <= CNT_W'(1);
            r_d        <= '0;
            r_l        <= '0;
        end else if (start) begin
            r_cur_mode <= r_cfg_mode;
            r_cur_mask <= r_cfg_mask;
            r_cur_rows <= clamp_rows;
            r_cur_cols <= clamp_cols;
            r_cur_w    <= clamp_w;
            r_cur_h    <= clamp_h;
            r_n        <= n_n;
            r_d        <= n_d;
            r_l        <= n_l;
        end
    end

    // step counters and window centre positions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_s       <= '0;
            r_out_cnt <= '0;
            r_addr    <= '0;
            r_r1      <= '0;
            r_c1      <= '0;
            r_r2      <= '0;
            r_c2      <= '0;
        end else if (step) begin
            r_active <= 1'b1;
            r_s      <= (start ? '0 : r_s) + CNT_W'(1);
            r_addr   <= a_next;
            if (start) begin
                r_out_cnt <= '0;
                r_r1      <= '0;
                r_c1      <= '0;
                r_r2      <= '0;
                r_c2      <= '0;
            end else begin
                if (produce) begin
                    r_out_cnt <= r_out_cnt + CNT_W'(1);
                end
                if (adv1) begin
                    if (({1'b0, r_c1} + SIZE_W'(1)) == r_cur_w) begin
                        r_c1 <= '0;
                        r_r1 <= r_r1 + POS_W'(1);
                    end else begin
                        r_c1 <= r_c1 + ADDR_W'(1);
                    end
                end
                if (adv2) begin
                    if (({1'b0, r_c2} + SIZE_W'(1)) == r_cur_w) begin
                        r_c2 <= '0;
                        r_r2 <= r_r2 + POS_W'(1);
                    end else begin
                        r_c2 <= r_c2 + ADDR_W'(1);
                    end
                end
            end
        end
    end

    // line stores and window shift registers
    always_ff @(posedge i_clk) begin
        if (step) begin
            mem1[a_eff] <= wv1;
            mem2[a_eff] <= wv2;
            r_rd1       <= mem1[a_next];
            r_rd2       <= mem2[a_next];
            r_last1     <= wv1;
            r_last2     <= wv2;
            r_byp       <= (w_eff == SIZE_W'(1));
            for (int r = 0; r < MAX_ELEMENT; r++) begin
                r_h1[r] <= nw1[r][MAX_ELEMENT-2:0];
                r_h2[r] <= nw2[r][MAX_ELEMENT-2:0];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (produce) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_out_data.foreground   <= (r_cur_mode == MODE_OPEN || r_cur_mode == MODE_CLOSE)
                                       ? res2 : res1;
            r_out_data.end_of_frame <= (r_out_cnt == r_n - CNT_W'(1));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // a result is only written into a free or emptying result register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        produce |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

    // the result count never passes the frame size
    a_out_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_out_cnt <= r_n))
        else $error("result count beyond frame");

    // the frame's last result leaves the counter at the frame size
    a_eof_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (produce && (r_out_cnt == r_n - CNT_W'(1))) |=> (r_out_cnt == r_n))
        else $error("end of frame out of step with count");

    // no item is taken while the windows step on their own
    a_auto_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        auto_step |-> !o_in_ready)
        else $error("item taken during self stepping");

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the binary morphology filter: predicts every result pixel and compares.
`timescale 1ns / 100ps

module tb_top;
    import bmf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam int STORE_BITS = MAX_WIDTH * MAX_HEIGHT;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    binary_morphology_filter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow registers as written
    logic [1:0]  sh_mode = MODE_ERODE;
    logic [24:0] sh_mask = 25'd2274;
    logic [2:0]  sh_rows = 3'd3;
    logic [2:0]  sh_cols = 3'd3;
    logic [10:0] sh_width = 11'd1024;
    logic [10:0] sh_height = 11'd1024;

    // frame state latched at the first pixel
    bit          fr_active = 1'b0;
    logic [1:0]  fr_mode;
    logic [24:0] fr_mask;
    int          fr_rows, fr_cols, fr_w = 1, fr_h = 1;
    int          fr_total = 1, fr_lag = 0;
    int          in_pos = 0, out_pos = 0, tick_cnt = 0;
    bit          pix_store [STORE_BITS];

    t_out_item   expected_px [$];
    int          err_cnt = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_cnt = 0;

    function automatic int clamp_size(input int v, input int hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    // one erosion or dilation pass at (x, y); nested runs the inner pass per tap
    function automatic bit morph_at(input bit dil, input bit nested, input bit inner_dil,
                                    input int x, input int y);
        int ar, ac, i, j;
        bit val;
        ar = fr_rows / 2;
        ac = fr_cols / 2;
        for (int u = 0; u < fr_rows; u++) begin
            for (int v = 0; v < fr_cols; v++) begin
                if (!fr_mask[u*MAX_ELEMENT+v]) continue;
                if (dil) begin
                    i = x - u + ar;
                    j = y - v + ac;
                end else begin
                    i = x + u - ar;
                    j = y + v - ac;
                end
                if (i < 0 || i >= fr_h || j < 0 || j >= fr_w) begin
                    if (dil) continue;
                    return 1'b0;
                end
                val = nested ? morph_at(inner_dil, 1'b0, 1'b0, i, j) : pix_store[i*fr_w+j];
                if (dil && val) return 1'b1;
                if (!dil && !val) return 1'b0;
            end
        end
        return !dil;
    endfunction

    function automatic void push_result();
        t_out_item r;
        int x, y;
        x = out_pos / fr_w;
        y = out_pos % fr_w;
        case (fr_mode)
            MODE_ERODE:  r.foreground = morph_at(1'b0, 1'b0, 1'b0, x, y);
            MODE_DILATE: r.foreground = morph_at(1'b1, 1'b0, 1'b0, x, y);
            MODE_OPEN:   r.foreground = morph_at(1'b1, 1'b1, 1'b0, x, y);
            default:     r.foreground = morph_at(1'b0, 1'b1, 1'b1, x, y);
        endcase
        r.end_of_frame = (out_pos + 1 == fr_total);
        out_pos++;
        expected_px.push_back(r);
    endfunction

    // advance the filter state by one accepted item
    function automatic void predict_item(input t_in_item it);
        int d;
        if (it.cmd == CMD_PIXEL) begin
            if (!fr_active || in_pos >= fr_total) begin
                fr_mode  = sh_mode;
                fr_mask  = sh_mask;
                fr_rows  = clamp_size(int'(sh_rows), MAX_ELEMENT);
                fr_cols  = clamp_size(int'(sh_cols), MAX_ELEMENT);
                fr_w     = clamp_size(int'(sh_width), MAX_WIDTH);
                fr_h     = clamp_size(int'(sh_height), MAX_HEIGHT);
                fr_total = fr_w * fr_h;
                d        = HALF * fr_w + HALF;
                fr_lag   = (fr_mode >= MODE_OPEN) ? 2 * d : d;
                if (fr_lag > fr_total) fr_lag = fr_total;
                in_pos = 0;
                out_pos = 0;
                tick_cnt = 0;
                fr_active = 1'b1;
            end
            pix_store[in_pos] = (it.pixel != 8'd0);
            in_pos++;
            tick_cnt++;
            if (tick_cnt > fr_lag && out_pos < fr_total) push_result();
        end else if (fr_active && in_pos >= fr_total && out_pos < fr_total) begin
            tick_cnt++;
            push_result();
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_out_item exp_px;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_px.size() == 0) begin
                $display("%0t: unexpected result, actual fg=%0b eof=%0b", $realtime,
                         o_out_data.foreground, o_out_data.end_of_frame);
                err_cnt++;
            end else begin
                exp_px = expected_px.pop_front();
                if (exp_px.foreground !== o_out_data.foreground) begin
                    $display("%0t: foreground mismatch, expected %0b actual %0b", $realtime,
                             exp_px.foreground, o_out_data.foreground);
                    err_cnt++;
                end
                if (exp_px.end_of_frame !== o_out_data.end_of_frame) begin
                    $display("%0t: end_of_frame mismatch, expected %0b actual %0b", $realtime,
                             exp_px.end_of_frame, o_out_data.end_of_frame);
                    err_cnt++;
                end
            end
        end
    end

    // receiver: random stalls plus an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_item(input logic cmd, input logic [7:0] px);
        t_in_item it;
        it.cmd = cmd;
        it.pixel = px;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_item(it);
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // wait for all results, then let a short frame's self-stepping finish
    task automatic wait_idle();
        int lim;
        int wmax;
        stop_sending();
        lim = 0;
        while (expected_px.size() != 0 && lim < 400000) begin
            @(posedge i_clk);
            lim++;
        end
        if (expected_px.size() != 0) begin
            $display("%0t: %0d results never arrived", $realtime, expected_px.size());
            err_cnt++;
            expected_px.delete();
        end
        wmax = clamp_size(int'(sh_width), MAX_WIDTH);
        if (fr_w > wmax) wmax = fr_w;
        repeat (4 * wmax + 16) @(posedge i_clk);
    endtask

    // register write; the block is idle when this is called
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_MODE:   sh_mode = val[1:0];
            REG_MASK:   sh_mask = val[24:0];
            REG_ROWS:   sh_rows = val[2:0];
            REG_COLS:   sh_cols = val[2:0];
            REG_WIDTH:  sh_width = val[10:0];
            REG_HEIGHT: sh_height = val[10:0];
            default: ;
        endcase
    endtask

    task automatic set_all(input logic [1:0] m, input logic [24:0] mask, input int rows,
                           input int cols, input int w, input int h);
        cfg_write(REG_MODE, CFG_DATA_W'(m));
        cfg_write(REG_MASK, mask);
        cfg_write(REG_ROWS, CFG_DATA_W'(rows));
        cfg_write(REG_COLS, CFG_DATA_W'(cols));
        cfg_write(REG_WIDTH, CFG_DATA_W'(w));
        cfg_write(REG_HEIGHT, CFG_DATA_W'(h));
    endtask

    // one frame; keep_drains < 0 drains everything, noisy adds stray drain items
    task automatic run_frame(input int fg_pct, input int keep_drains, input bit noisy);
        int n, sent;
        n = clamp_size(int'(sh_width), MAX_WIDTH) * clamp_size(int'(sh_height), MAX_HEIGHT);
        for (int p = 0; p < n; p++) begin
            if (noisy && $urandom_range(9) == 0) send_item(CMD_DRAIN, 8'($urandom));
            if ($urandom_range(99) < fg_pct) send_item(CMD_PIXEL, 8'($urandom_range(1, 255)));
            else send_item(CMD_PIXEL, 8'd0);
        end
        sent = 0;
        while (out_pos < fr_total && (keep_drains < 0 || sent < keep_drains)) begin
            send_item(CMD_DRAIN, 8'($urandom));
            sent++;
        end
        if (noisy) repeat ($urandom_range(2)) send_item(CMD_DRAIN, 8'($urandom));
    endtask

    // defaults after reset: erosion with a 3x3 cross
    task automatic test_reset_defaults();
        cfg_write(REG_WIDTH, CFG_DATA_W'(6));
        cfg_write(REG_HEIGHT, CFG_DATA_W'(5));
        run_frame(80, -1, 1'b0);
        wait_idle();
    endtask

    // every mode with full and empty elements, and an ignored register index
    task automatic test_modes();
        for (int m = 0; m < 4; m++) begin
            set_all(2'(m), 25'h1FFFFFF, 5, 5, 5, 3);
            run_frame(85, -1, 1'b0);
            wait_idle();
            cfg_write(REG_MASK, 25'd0);
            run_frame(50, -1, 1'b0);
            wait_idle();
        end
        cfg_write(REG_SPARE, 25'h1FFFFFF);
        run_frame(60, -1, 1'b0);
        wait_idle();
    endtask

    // out-of-range sizes, stray mask bits, frame-size extremes
    task automatic test_size_extremes();
        set_all(MODE_CLOSE, 25'h1555555, 0, 7, 5, 4);
        run_frame(50, -1, 1'b1);
        wait_idle();
        set_all(MODE_OPEN, 25'h1ABCDEF, 2, 3, 0, 3);
        run_frame(60, -1, 1'b0);
        wait_idle();
        set_all(MODE_DILATE, 25'd2274, 3, 3, 1, 1);
        run_frame(100, -1, 1'b1);
        wait_idle();
        set_all(MODE_ERODE, 25'h1FFFFFF, 5, 5, 12, 2);
        run_frame(90, -1, 1'b0);
        wait_idle();
        set_all(MODE_CLOSE, 25'd2274, 3, 3, 2, 0);
        run_frame(40, -1, 1'b0);
        wait_idle();
        // pending results dropped by a new frame
        set_all(MODE_OPEN, 25'h0739CE0, 5, 5, 8, 3);
        run_frame(70, 2, 1'b0);
        run_frame(70, -1, 1'b1);
        wait_idle();
    endtask

    // long receiver hold-off that fills the block, then a full pause of the sender
    task automatic test_backpressure();
        set_all(MODE_DILATE, 25'h0E8E2E0, 3, 5, 6, 5);
        hold_cnt = 3000;
        run_frame(50, -1, 1'b0);
        stop_sending();
        while (expected_px.size() != 0) @(posedge i_clk);
        run_frame(50, -1, 1'b1);
        wait_idle();
    endtask

    task automatic test_random();
        int sent_items;
        int sk;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            sent_items = 0;
            while (sent_items < 30) begin
                sk = $urandom_range(9);
                set_all(2'($urandom_range(3)),
                        (sk == 0) ? 25'h1FFFFFF : (sk == 1) ? 25'd0 : 25'($urandom),
                        (sk == 2) ? $urandom : $urandom_range(1, 5),
                        (sk == 3) ? $urandom : $urandom_range(1, 5),
                        (sk == 4) ? $urandom_range(0, 2047) % 12 : $urandom_range(1, 10),
                        $urandom_range(1, 6));
                sent_items += 2 * clamp_size(int'(sh_width), MAX_WIDTH)
                              * clamp_size(int'(sh_height), MAX_HEIGHT);
                run_frame($urandom_range(100), ($urandom_range(7) == 0) ? 3 : -1,
                          $urandom_range(3) == 0);
                wait_idle();
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_modes();
        test_size_extremes();
        test_backpressure();
        test_random();
        wait_idle();
        if (err_cnt == 0) begin
            $display("PASS binary_morphology_filter");
        end else begin
            $display("FAIL binary_morphology_filter");
        end
        $finish;
    end

    // run limit
    initial begin
        #40ms;
        $display("FAIL binary_morphology_filter");
        $finish;
    end

endmodule
